@@ src/oscsp_pkg.sv @@
// ----------------------------------------------------------------------------
// oscsp_pkg
// shared types and constants of the one-shot click sample player
// ----------------------------------------------------------------------------
package oscsp_pkg;

  localparam int unsigned MaxSamplesDef = 4096;

  // field widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned LenW    = 13;
  localparam int unsigned LoadAW  = 12;
  // compare width, wide enough for any depth up to 65536
  localparam int unsigned CmpW    = 17;

  // item kinds
  localparam logic KindLoad  = 1'b0;
  localparam logic KindFrame = 1'b1;

  // table select
  localparam logic TabNormal = 1'b0;
  localparam logic TabAccent = 1'b1;

  // register indexes
  localparam logic RegNormalLen = 1'b0;
  localparam logic RegAccentLen = 1'b1;

  // per-frame information travelling beside the memory read
  typedef struct packed {
    logic use_mem;
    logic active;
  } frame_info_t;

endpackage

@@ src/oscsp_sample_mem.sv @@
// ----------------------------------------------------------------------------
// oscsp_sample_mem
// sample table memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module oscsp_sample_mem import oscsp_pkg::*; #(
  parameter int unsigned AddrW = 13
) (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [AddrW-1:0]   wr_addr_i,
  input  logic [SampleW-1:0] wr_data_i,
  input  logic               rd_en_i,
  input  logic [AddrW-1:0]   rd_addr_i,
  output logic [SampleW-1:0] rd_data_o
);

  logic [SampleW-1:0] mem_q [2**AddrW];
  logic [SampleW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ src/oscsp_voice.sv @@
// ----------------------------------------------------------------------------
// oscsp_voice
// length registers, voice state and table address generation
// ----------------------------------------------------------------------------
module oscsp_voice import oscsp_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MaxSamplesDef,
  parameter int unsigned AW          = $clog2(MAX_SAMPLES)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [LenW-1:0]    cfg_data_i,
  input  logic               fire_i,
  input  logic               kind_i,
  input  logic               table_select_i,
  input  logic [LoadAW-1:0]  load_address_i,
  input  logic [SampleW-1:0] load_value_i,
  input  logic               running_i,
  input  logic               trigger_i,
  input  logic               accent_i,
  output logic               wr_en_o,
  output logic [AW:0]        wr_addr_o,
  output logic [SampleW-1:0] wr_data_o,
  output logic               rd_en_o,
  output logic [AW:0]        rd_addr_o,
  output logic               push_o,
  output frame_info_t        info_o
);

  localparam logic [CmpW-1:0] MaxLen = CmpW'(MAX_SAMPLES);

  logic [LenW-1:0] normal_len_q, accent_len_q;
  logic            playing_q, playing_d;
  logic            accent_q, accent_d;
  logic [LenW-1:0] pos_q, pos_d;

  logic            frame;
  logic            play_c;
  logic [LenW-1:0] pos_c;
  logic [CmpW-1:0] pos_w;
  logic [CmpW-1:0] len_raw, len_c;
  logic            hit;
  logic [CmpW-1:0] load_addr_w;

  always_comb begin
    frame   = fire_i && (kind_i == KindFrame);
    play_c  = trigger_i ? 1'b1 : playing_q;
    accent_d = accent_q;
    pos_d    = pos_q;
    playing_d = playing_q;
    if (trigger_i) begin
      accent_d = accent_i;
    end
    pos_c   = trigger_i ? '0 : pos_q;
    pos_w   = CmpW'(pos_c);
    len_raw = CmpW'(accent_d ? accent_len_q : normal_len_q);
    len_c   = (len_raw > MaxLen) ? MaxLen : len_raw;
    hit     = play_c && (pos_w < len_c);

    info_o = '0;
    if (frame) begin
      if (!running_i) begin
        // silent frame, voice stops, position left as it was
        playing_d = 1'b0;
        accent_d  = accent_q;
      end else begin
        pos_d         = hit ? pos_c + LenW'(1) : pos_c;
        playing_d     = play_c && (CmpW'(pos_d) < len_c);
        info_o.use_mem = hit;
        info_o.active  = playing_d;
      end
    end else begin
      accent_d = accent_q;
    end

    rd_en_o   = frame && running_i && hit;
    rd_addr_o = {accent_d, pos_w[AW-1:0]};
    push_o    = frame;

    load_addr_w = CmpW'(load_address_i);
    wr_en_o     = fire_i && (kind_i == KindLoad) && (load_addr_w < MaxLen);
    wr_addr_o   = {table_select_i, load_addr_w[AW-1:0]};
    wr_data_o   = load_value_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_len_q <= '0;
      accent_len_q <= '0;
      playing_q    <= 1'b0;
      accent_q     <= 1'b0;
      pos_q        <= '0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == RegNormalLen)) begin
        normal_len_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_idx_i == RegAccentLen)) begin
        accent_len_q <= cfg_data_i;
      end
      playing_q <= playing_d;
      accent_q  <= accent_d;
      pos_q     <= pos_d;
    end
  end

endmodule

@@ src/oscsp_out_stage.sv @@
// ----------------------------------------------------------------------------
// oscsp_out_stage
// read-wait stage and output register with backpressure
// ----------------------------------------------------------------------------
module oscsp_out_stage import oscsp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  frame_info_t        info_i,
  input  logic [SampleW-1:0] rd_data_i,
  output logic               take_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SampleW-1:0] sample_o,
  output logic               voice_active_o
);

  logic               s1_vld_q;
  frame_info_t        s1_info_q;
  logic               out_vld_q;
  logic [SampleW-1:0] out_sample_q;
  logic               out_active_q;
  logic               out_free, s1_move;

  assign out_free = !out_vld_q || out_ready_i;
  assign s1_move  = s1_vld_q && out_free;
  assign take_o   = !s1_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (take_o) begin
        s1_vld_q <= push_i;
      end
      if (s1_move) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && push_i) begin
      s1_info_q <= info_i;
    end
    // memory data is valid exactly while the frame sits in the wait stage
    if (s1_move) begin
      out_sample_q <= s1_info_q.use_mem ? rd_data_i : '0;
      out_active_q <= s1_info_q.active;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign sample_o       = out_sample_q;
  assign voice_active_o = out_active_q;

endmodule

@@ src/one_shot_click_sample_player.sv @@
// ----------------------------------------------------------------------------
// one_shot_click_sample_player
// one-voice one-shot click sample player with normal and accent tables
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries load beats and frame beats.
// A load beat writes one sample into the normal or accent table and gives
// no output. A frame beat gives exactly one output beat (sample_o,
// voice_active_o) on the out_valid_o/out_ready_i channel, in order.
// Both tables sit in one synchronous memory; the voice state update is done
// at input accept, and the table read returns in the next cycle.
// Throughput: one beat per cycle while the output does not stall, set by
// the single memory read port. The user must write lengths over cfg_we_i,
// cfg_idx_i and cfg_data_i only while idle; the block does not enforce it.
// Reset clears the lengths, the voice state and both pipeline stages;
// table contents are undefined until loaded.
// When the receiver stalls, the output register holds its beat, one more
// frame waits in the read stage, and in_ready_o drops after that.
// ----------------------------------------------------------------------------
module one_shot_click_sample_player import oscsp_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MaxSamplesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [LenW-1:0]           cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      kind_i,
  input  logic                      table_select_i,
  input  logic [LoadAW-1:0]         load_address_i,
  input  logic signed [SampleW-1:0] load_value_i,
  input  logic                      running_i,
  input  logic                      trigger_i,
  input  logic                      accent_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SampleW-1:0] sample_o,
  output logic                      voice_active_o
);

  localparam int unsigned AW = $clog2(MAX_SAMPLES);

  logic               fire, take;
  logic               wr_en, rd_en, push;
  logic [AW:0]        wr_addr, rd_addr;
  logic [SampleW-1:0] wr_data, rd_data, sample_u;
  frame_info_t        info;

  assign in_ready_o = take;
  assign fire       = in_valid_i && take;

  oscsp_voice #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .AW          (AW)
  ) u_voice (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .fire_i         (fire),
    .kind_i         (kind_i),
    .table_select_i (table_select_i),
    .load_address_i (load_address_i),
    .load_value_i   (load_value_i),
    .running_i      (running_i),
    .trigger_i      (trigger_i),
    .accent_i       (accent_i),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .push_o         (push),
    .info_o         (info)
  );

  oscsp_sample_mem #(
    .AddrW (AW + 1)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  oscsp_out_stage u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .info_i         (info),
    .rd_data_i      (rd_data),
    .take_o         (take),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_o       (sample_u),
    .voice_active_o (voice_active_o)
  );

  assign sample_o = sample_u;

endmodule

@@ src/oscsp_checker.sv @@
// ----------------------------------------------------------------------------
// oscsp_checker
// port-level checks of the click sample player
// ----------------------------------------------------------------------------
module oscsp_checker import oscsp_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      kind_i,
  input logic                      running_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic signed [SampleW-1:0] sample_o,
  input logic                      voice_active_o
);

  // output register is empty while in reset
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(sample_o) && $stable(voice_active_o))
    else $error("stalled output beat changed");

  // input only backs up when the output is full and stalled
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // a frame with running low comes out silent and inactive
  a_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (kind_i == KindFrame) && !running_i)
      ##1 out_ready_i |=>
      out_valid_o && (sample_o == '0) && !voice_active_o)
    else $error("stopped frame not silent");

endmodule

bind one_shot_click_sample_player oscsp_checker u_oscsp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .kind_i         (kind_i),
  .running_i      (running_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .sample_o       (sample_o),
  .voice_active_o (voice_active_o)
);

@@ sim/one_shot_click_sample_player_test.sv @@
// ----------------------------------------------------------------------------
// one_shot_click_sample_player_test
// self-checking bench for the one-shot click sample player
// ----------------------------------------------------------------------------
// Load beats and frame beats go in over valid/ready with random gaps, and the
// output side stalls at random. A scoreboard keeps its own copy of both
// waveform tables, the two lengths and the voice state. Each accepted frame
// queues the sample and voice flag it should give, and each output beat is
// checked against the oldest one. A directed part covers the table extremes,
// zero length, lengths above the table depth, a trigger that cuts a voice, a
// trigger with running low and a length cut while a voice plays. Random
// phases follow, each with new lengths. A frame that would read a table entry
// never loaded is turned into a load of that entry.
// ----------------------------------------------------------------------------
module one_shot_click_sample_player_test;
  import oscsp_pkg::*;

  localparam int unsigned Depth      = MaxSamplesDef;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseBeats = 150;

  typedef struct packed {
    logic               kind;
    logic               table_select;
    logic [LoadAW-1:0]  load_address;
    logic [SampleW-1:0] load_value;
    logic               running;
    logic               trigger;
    logic               accent;
  } beat_t;

  typedef struct packed {
    logic [SampleW-1:0] smp;
    logic               active;
  } frame_out_t;

  class click_scoreboard;
    logic [SampleW-1:0] wave [2][Depth];
    bit                 loaded [2][Depth];
    logic [LenW-1:0]    wave_len [2];
    bit                 playing;
    bit                 play_accent;
    int unsigned        position;
    frame_out_t         frames_q [$];
    int                 errors;

    function new();
      wave_len[0] = '0;
      wave_len[1] = '0;
      playing     = 1'b0;
      play_accent = 1'b0;
      position    = 0;
      errors      = 0;
    endfunction

    function void set_length(input logic idx, input logic [LenW-1:0] len);
      wave_len[idx] = len;
    endfunction

    // lengths above the table depth saturate
    function int unsigned eff_len(input bit acc);
      int unsigned len;
      len = wave_len[acc];
      return (len > Depth) ? Depth : len;
    endfunction

    // which table entry a frame beat would read, if any
    function bit frame_reads(input beat_t b, output bit acc, output int unsigned pos);
      bit play;
      play = playing;
      acc  = play_accent;
      pos  = position;
      if (!b.running) return 1'b0;
      if (b.trigger) begin
        play = 1'b1;
        acc  = b.accent;
        pos  = 0;
      end
      return play && (pos < eff_len(acc));
    endfunction

    function int pending();
      return frames_q.size();
    endfunction

    function void note_input(input beat_t b);
      frame_out_t  res;
      bit          rd;
      bit          acc;
      int unsigned pos;
      if (b.kind == KindLoad) begin
        wave[b.table_select][b.load_address]   = b.load_value;
        loaded[b.table_select][b.load_address] = 1'b1;
        return;
      end
      res.smp    = '0;
      res.active = 1'b0;
      if (!b.running) begin
        playing = 1'b0;
        frames_q.push_back(res);
        return;
      end
      rd = frame_reads(b, acc, pos);
      if (b.trigger) begin
        playing     = 1'b1;
        play_accent = b.accent;
        position    = 0;
      end
      if (rd) begin
        res.smp  = wave[acc][pos];
        position = position + 1;
      end
      // current length applies every frame, also after a change mid-voice
      if (position >= eff_len(play_accent)) playing = 1'b0;
      res.active = playing;
      frames_q.push_back(res);
    endfunction

    function void check_result(input logic [SampleW-1:0] smp, input logic active);
      frame_out_t want;
      if (frames_q.size() == 0) begin
        $display("%0t: output beat with none expected: sample %0d active %0b",
                 $time, $signed(smp), active);
        errors++;
        return;
      end
      want = frames_q.pop_front();
      if (want.smp !== smp) begin
        $display("%0t: sample mismatch, expected %0d got %0d",
                 $time, $signed(want.smp), $signed(smp));
        errors++;
      end
      if (want.active !== active) begin
        $display("%0t: voice_active mismatch, expected %0b got %0b",
                 $time, want.active, active);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic                cfg_idx_i;
  logic [LenW-1:0]     cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                kind_i;
  logic                table_select_i;
  logic [LoadAW-1:0]   load_address_i;
  logic [SampleW-1:0]  load_value_i;
  logic                running_i;
  logic                trigger_i;
  logic                accent_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [SampleW-1:0]  sample_o;
  logic                voice_active_o;

  click_scoreboard sb = new();
  bit              quiet = 1'b0;
  int unsigned     cycles = 0;

  one_shot_click_sample_player uut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .kind_i,
    .table_select_i,
    .load_address_i,
    .load_value_i,
    .running_i,
    .trigger_i,
    .accent_i,
    .out_valid_o,
    .out_ready_i,
    .sample_o,
    .voice_active_o
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL one_shot_click_sample_player");
      $finish;
    end
  end

  // mostly short gaps, a few long ones, none in quiet phases
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic beat_t any_beat();
    beat_t       b;
    logic [31:0] r0;
    logic [31:0] r1;
    r0 = $urandom();
    r1 = $urandom();
    b.kind         = r0[16];
    b.table_select = r0[0];
    b.load_address = r0[12:1];
    b.load_value   = r1[15:0];
    b.running      = r0[13];
    b.trigger      = r0[14];
    b.accent       = r0[15];
    return b;
  endfunction

  function automatic beat_t load_beat(input logic sel, input logic [LoadAW-1:0] addr,
                                      input logic [SampleW-1:0] val);
    beat_t b;
    b = any_beat();
    b.kind         = KindLoad;
    b.table_select = sel;
    b.load_address = addr;
    b.load_value   = val;
    return b;
  endfunction

  function automatic beat_t frame_beat(input logic run, input logic trig, input logic acc);
    beat_t b;
    b = any_beat();
    b.kind    = KindFrame;
    b.running = run;
    b.trigger = trig;
    b.accent  = acc;
    return b;
  endfunction

  function automatic beat_t random_beat();
    beat_t       b;
    bit          acc;
    int unsigned pos;
    b = any_beat();
    if ($urandom_range(0, 99) < 35) begin
      b.kind = KindLoad;
      if ($urandom_range(0, 9) < 7) b.load_address = LoadAW'($urandom_range(0, 63));
      case ($urandom_range(0, 19))
        0: b.load_value = 16'h7fff;
        1: b.load_value = 16'h8000;
        2: b.load_value = 16'hffff;
        3: b.load_value = 16'h0000;
        default: ;
      endcase
    end else begin
      b.kind    = KindFrame;
      b.running = ($urandom_range(0, 19) != 0);
      b.trigger = ($urandom_range(0, 5) == 0);
      // never play an entry that was not loaded: load it instead
      if (sb.frame_reads(b, acc, pos) && !sb.loaded[acc][pos]) begin
        b.kind         = KindLoad;
        b.table_select = acc;
        b.load_address = LoadAW'(pos);
      end
    end
    return b;
  endfunction

  function automatic logic [LenW-1:0] pick_len();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return LenW'(Depth);
      2:       return LenW'($urandom_range(Depth + 1, (1 << LenW) - 1));
      3, 4:    return LenW'($urandom_range(1, 4));
      default: return LenW'($urandom_range(5, 48));
    endcase
  endfunction

  task automatic send_beat(input beat_t b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= b.kind;
    table_select_i <= b.table_select;
    load_address_i <= b.load_address;
    load_value_i   <= b.load_value;
    running_i      <= b.running;
    trigger_i      <= b.trigger;
    accent_i       <= b.accent;
    // inputs only move at rising edges, so the negedge view holds at the next edge
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    sb.note_input(b);
  endtask

  // loads give no output beat, so allow for one still in the pipe
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_lengths(input logic [LenW-1:0] n_len, input logic [LenW-1:0] a_len);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegNormalLen;
    cfg_data_i <= n_len;
    @(posedge clk_i);
    cfg_idx_i  <= RegAccentLen;
    cfg_data_i <= a_len;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_length(RegNormalLen, n_len);
    sb.set_length(RegAccentLen, a_len);
  endtask

  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(sample_o, voice_active_o);
  end

  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= RegNormalLen;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    kind_i         <= KindLoad;
    table_select_i <= TabNormal;
    load_address_i <= '0;
    load_value_i   <= '0;
    running_i      <= 1'b0;
    trigger_i      <= 1'b0;
    accent_i       <= 1'b0;
    out_ready_i    <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // right after reset: trigger with running low, then zero-length triggers
    send_beat(frame_beat(1'b0, 1'b1, 1'b1));
    send_beat(frame_beat(1'b1, 1'b1, 1'b0));
    send_beat(frame_beat(1'b1, 1'b1, 1'b1));
    send_beat(load_beat(TabNormal, 12'd0, 16'h7fff));
    send_beat(load_beat(TabNormal, 12'd1, 16'h8000));
    send_beat(load_beat(TabNormal, 12'd2, 16'hffff));
    send_beat(load_beat(TabNormal, 12'hfff, 16'h1234));
    send_beat(load_beat(TabAccent, 12'd0, 16'h8000));
    send_beat(load_beat(TabAccent, 12'd1, 16'h7fff));
    send_beat(load_beat(TabAccent, 12'd2, 16'h0001));
    send_beat(load_beat(TabAccent, 12'hfff, 16'hffff));
    wait_idle();
    // accent length far above the table depth
    write_lengths(13'd3, 13'h1fff);
    send_beat(frame_beat(1'b1, 1'b1, 1'b0));
    send_beat(frame_beat(1'b1, 1'b0, 1'b1));
    send_beat(frame_beat(1'b1, 1'b0, 1'b0));
    send_beat(frame_beat(1'b1, 1'b0, 1'b0));
    send_beat(frame_beat(1'b1, 1'b1, 1'b1));
    send_beat(frame_beat(1'b1, 1'b0, 1'b0));
    // new trigger cuts the accent voice
    send_beat(frame_beat(1'b1, 1'b1, 1'b0));
    send_beat(frame_beat(1'b0, 1'b1, 1'b1));
    send_beat(frame_beat(1'b1, 1'b0, 1'b0));
    send_beat(frame_beat(1'b1, 1'b1, 1'b0));
    wait_idle();
    // shorten the length under a playing voice
    write_lengths(13'd1, 13'h1fff);
    send_beat(frame_beat(1'b1, 1'b0, 1'b0));
    wait_idle();
    write_lengths(LenW'(Depth), 13'd0);
    send_beat(frame_beat(1'b1, 1'b1, 1'b1));
    send_beat(frame_beat(1'b1, 1'b1, 1'b0));
    send_beat(frame_beat(1'b1, 1'b0, 1'b0));

    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      write_lengths(pick_len(), pick_len());
      quiet = (phase % 3 == 2);
      for (int k = 0; k < PhaseBeats; k++) send_beat(random_beat());
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS one_shot_click_sample_player");
    end else begin
      $display("FAIL one_shot_click_sample_player");
    end
    $finish;
  end

endmodule
